/* hdl/mfpr_pkg.sv */
// Package for the marker-framed packet receiver.
// Holds widths, register defaults, register index codes and the control structs.
// No dependencies.
package mfpr_pkg;

  localparam int BYTE_W           = 8;
  localparam int CFG_IDX_W        = 2;
  localparam int BUFFER_DEPTH_DEF = 64;

  localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'd64;  // at sign
  localparam logic [BYTE_W-1:0] FIRST_TERM_RST   = 8'd13;  // carriage return
  localparam logic [BYTE_W-1:0] SECOND_TERM_RST  = 8'd10;  // line feed

  localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_TERM   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_TERM  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_pkt;   // start marker seen: reset fill count and overflow flag
    logic store_byte;  // write the received byte at the fill position
    logic set_ovf;     // payload byte dropped on a full buffer
    logic load_burst;  // second terminator seen: prepare the readout
    logic rd_en;       // read the buffer at the readout index
    logic rd_inc;      // step the readout index
  } mfpr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic eq_start;
    logic eq_first;
    logic eq_second;
    logic buf_full;
    logic burst_last;
  } mfpr_stat_t;

endpackage

/* hdl/mfpr_if.sv */
// Handshake channel interfaces of the marker-framed packet receiver.
// Depends on mfpr_pkg for the field widths.
interface mfpr_in_if import mfpr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface mfpr_out_if import mfpr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] payload_byte;
  logic              byte_valid;
  logic              is_last;
  logic              overflowed;

  modport source (output valid, output payload_byte, output byte_valid,
                  output is_last, output overflowed, input ready);
  modport sink (input valid, input payload_byte, input byte_valid,
                input is_last, input overflowed, output ready);
endinterface

interface mfpr_cfg_if import mfpr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [BYTE_W-1:0]    wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

/* hdl/mfpr_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module mfpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/mfpr_ctrl.sv */
// Controller of the marker-framed packet receiver: byte parser and burst sequencer.
// Depends on mfpr_pkg for the command and status structs.
module mfpr_ctrl import mfpr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  mfpr_stat_t stat,
  output mfpr_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_WAIT,
    ST_COLLECT,
    ST_AWAIT_END,
    ST_READ,
    ST_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_acc;
  logic   out_acc;

  assign in_ready  = (state_r == ST_WAIT) || (state_r == ST_COLLECT) ||
                     (state_r == ST_AWAIT_END);
  assign out_valid = (state_r == ST_EMIT);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_WAIT: begin
        if (in_acc && stat.eq_start) begin
          cmd.clear_pkt = 1'b1;
          state_nxt     = ST_COLLECT;
        end
      end
      ST_COLLECT: begin
        if (in_acc) begin
          // The terminator test comes before storing.
          if (stat.eq_first) begin
            state_nxt = ST_AWAIT_END;
          end else if (!stat.buf_full) begin
            cmd.store_byte = 1'b1;
          end else begin
            cmd.set_ovf = 1'b1;
          end
        end
      end
      ST_AWAIT_END: begin
        if (in_acc && stat.eq_second) begin
          cmd.load_burst = 1'b1;
          state_nxt      = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_acc) begin
          if (stat.burst_last) begin
            state_nxt = ST_WAIT;
          end else begin
            cmd.rd_inc = 1'b1;
            state_nxt  = ST_READ;
          end
        end
      end
      default: state_nxt = ST_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_WAIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hdl/mfpr_dpath.sv */
// Datapath of the marker-framed packet receiver: configuration registers,
// byte compares, fill count, overflow flag, packet buffer and readout index.
// Depends on mfpr_pkg and mfpr_ram.
module mfpr_dpath import mfpr_pkg::*; #(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mfpr_cmd_t            cmd,
  output mfpr_stat_t           stat,
  input  logic [BYTE_W-1:0]    rx_byte,
  input  logic                 cfg_wr,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_wdata,
  output logic [BYTE_W-1:0]    payload_byte,
  output logic                 byte_valid,
  output logic                 is_last,
  output logic                 overflowed
);

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(BUFFER_DEPTH);

  logic [BYTE_W-1:0] start_marker_r;
  logic [BYTE_W-1:0] first_term_r;
  logic [BYTE_W-1:0] second_term_r;
  logic [CW-1:0]     fill_r;
  logic              ovf_r;
  logic [AW-1:0]     rd_idx_r;
  logic              empty_r;
  logic [BYTE_W-1:0] rd_data;
  logic              rd_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r <= START_MARKER_RST;
      first_term_r   <= FIRST_TERM_RST;
      second_term_r  <= SECOND_TERM_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_START_MARKER: start_marker_r <= cfg_wdata;
        REG_FIRST_TERM:   first_term_r   <= cfg_wdata;
        REG_SECOND_TERM:  second_term_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      ovf_r  <= 1'b0;
    end else begin
      if (cmd.clear_pkt) begin
        fill_r <= '0;
        ovf_r  <= 1'b0;
      end else begin
        if (cmd.store_byte) begin
          fill_r <= fill_r + CW'(1);
        end
        if (cmd.set_ovf) begin
          ovf_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r <= '0;
      empty_r  <= 1'b0;
    end else if (cmd.load_burst) begin
      rd_idx_r <= '0;
      empty_r  <= (fill_r == '0);
    end else if (cmd.rd_inc) begin
      rd_idx_r <= rd_idx_r + AW'(1);
    end
  end

  mfpr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (cmd.store_byte),
    .waddr (fill_r[AW-1:0]),
    .wdata (rx_byte),
    .re    (cmd.rd_en),
    .raddr (rd_idx_r),
    .rdata (rd_data)
  );

  assign rd_last = ((CW'(rd_idx_r) + CW'(1)) == fill_r);

  assign stat.eq_start   = (rx_byte == start_marker_r);
  assign stat.eq_first   = (rx_byte == first_term_r);
  assign stat.eq_second  = (rx_byte == second_term_r);
  assign stat.buf_full   = (fill_r == FULL_COUNT);
  assign stat.burst_last = empty_r || rd_last;

  // An empty packet shows a single marker result with no byte.
  assign payload_byte = empty_r ? '0 : rd_data;
  assign byte_valid   = !empty_r;
  assign is_last      = empty_r || rd_last;
  assign overflowed   = ovf_r;

endmodule

/* hdl/marker_framed_packet_receiver.sv */
// Top level of the marker-framed packet receiver.
// Depends on mfpr_pkg, the channel interfaces, mfpr_ctrl and mfpr_dpath.

// Bytes are taken one per cycle while the parser waits for the start marker,
// collects payload up to the first terminator and waits for the second
// terminator. The second terminator starts a burst of one result per stored
// byte (one marker result with byte_valid low for an empty packet); each
// result passes through a read state, which issues the buffer's registered
// read, and an emit state that presents it until the sink takes it, so the
// input is held from the second terminator until the last result is taken.
// No byte is taken during a burst. Payload past BUFFER_DEPTH bytes is dropped
// and flagged on every result of that packet through overflowed. The
// configuration port always accepts; writes are meant for idle periods.
module marker_framed_packet_receiver import mfpr_pkg::*; #(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  mfpr_in_if.sink    in_ch,
  mfpr_out_if.source out_ch,
  mfpr_cfg_if.sink   cfg_ch
);

  mfpr_cmd_t  cmd;
  mfpr_stat_t stat;

  assign cfg_ch.ready = 1'b1;

  mfpr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mfpr_dpath #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .stat         (stat),
    .rx_byte      (in_ch.rx_byte),
    .cfg_wr       (cfg_ch.valid && cfg_ch.ready),
    .cfg_index    (cfg_ch.reg_index),
    .cfg_wdata    (cfg_ch.wdata),
    .payload_byte (out_ch.payload_byte),
    .byte_valid   (out_ch.byte_valid),
    .is_last      (out_ch.is_last),
    .overflowed   (out_ch.overflowed)
  );

endmodule

/* hdl/mfpr_checker.sv */
// Port-level checks of the marker-framed packet receiver, bound to the top level.
// Depends on mfpr_pkg for the byte width.
module mfpr_checker import mfpr_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] out_payload_byte,
  input logic              out_byte_valid,
  input logic              out_is_last,
  input logic              out_overflowed
);

  // A stalled result keeps its contents.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload_byte) &&
      $stable(out_byte_valid) && $stable(out_is_last) && $stable(out_overflowed))
    else $error("stalled result changed");

  // No byte is taken while a burst is under way.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready during a burst");

  // The empty-packet marker is always flagged as the last result of its burst.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_byte_valid |-> out_is_last)
    else $error("empty marker not flagged last");

  // After the last result of a burst is taken, the parser is ready again.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_is_last |=> !out_valid && in_ready)
    else $error("burst did not end after its last result");

endmodule

bind marker_framed_packet_receiver mfpr_checker u_mfpr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_payload_byte (out_ch.payload_byte),
  .out_byte_valid   (out_ch.byte_valid),
  .out_is_last      (out_ch.is_last),
  .out_overflowed   (out_ch.overflowed)
);
